>>> src/aabb_pcc_pkg.sv
// Package with shared types, constants and command codes of the platform collision unit.
package aabb_pcc_pkg;

  localparam int unsigned MaxPlatformsDef = 64;
  localparam int unsigned CoordW = 16;
  localparam int unsigned SizeW = 15;
  localparam int unsigned SlotW = 6;
  localparam int unsigned CountW = 7;
  localparam int unsigned CorrW = 17;
  localparam int unsigned GapW = 18;
  localparam int unsigned SumW = 17;
  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned ApbDataW = 32;

  localparam logic CmdWrite = 1'b0;
  localparam logic CmdQuery = 1'b1;

  localparam logic RegPlatformCount = 1'b0;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic [SizeW-1:0]         w;
    logic [SizeW-1:0]         h;
  } entry_t;

  typedef struct packed {
    logic write_entry;
    logic load_query;
    logic scan_step;
    logic mag_load;
    logic result_load;
    logic result_hit;
  } dp_cmd_t;

  typedef struct packed {
    logic found;
    logic scan_done;
    logic out_free;
  } dp_status_t;

endpackage

>>> src/aabb_pcc_in_if.sv
// Request channel interface carrying table writes and queries.
interface aabb_pcc_in_if;
  logic                                       valid;
  logic                                       ready;
  logic                                       cmd;
  logic [aabb_pcc_pkg::SlotW-1:0]             slot;
  logic signed [aabb_pcc_pkg::CoordW-1:0]     rect_x;
  logic signed [aabb_pcc_pkg::CoordW-1:0]     rect_y;
  logic [aabb_pcc_pkg::SizeW-1:0]             rect_w;
  logic [aabb_pcc_pkg::SizeW-1:0]             rect_h;

  modport source (output valid, cmd, slot, rect_x, rect_y, rect_w, rect_h, input ready);
  modport sink (input valid, cmd, slot, rect_x, rect_y, rect_w, rect_h, output ready);
endinterface

>>> src/aabb_pcc_out_if.sv
// Result channel interface carrying the hit flag and the correction vector.
interface aabb_pcc_out_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   hit;
  logic signed [aabb_pcc_pkg::CorrW-1:0]  correction_x;
  logic signed [aabb_pcc_pkg::CorrW-1:0]  correction_y;

  modport source (output valid, hit, correction_x, correction_y, input ready);
  modport sink (input valid, hit, correction_x, correction_y, output ready);
endinterface

>>> src/aabb_pcc_ctrl.sv
// Controller state machine sequencing writes, the table scan and result selection.
module aabb_pcc_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     in_cmd_i,
  output logic                     in_ready_o,
  input  aabb_pcc_pkg::dp_status_t status_i,
  output aabb_pcc_pkg::dp_cmd_t    cmd_o
);

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StMag,
    StSel
  } state_e;

  state_e state_q;
  logic   found_q;
  logic   accept;

  assign in_ready_o = (state_q == StIdle);
  assign accept = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o = '0;
    cmd_o.write_entry = accept && (in_cmd_i == aabb_pcc_pkg::CmdWrite);
    cmd_o.load_query = accept && (in_cmd_i == aabb_pcc_pkg::CmdQuery);
    cmd_o.scan_step = (state_q == StScan) && !status_i.found;
    cmd_o.mag_load = (state_q == StMag);
    cmd_o.result_load = (state_q == StSel) && status_i.out_free;
    cmd_o.result_hit = found_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      found_q <= 1'b0;
    end else begin
      case (state_q)
        StIdle: begin
          if (accept && (in_cmd_i == aabb_pcc_pkg::CmdQuery)) begin
            state_q <= StScan;
          end
        end
        StScan: begin
          if (status_i.found) begin
            found_q <= 1'b1;
            state_q <= StMag;
          end else if (status_i.scan_done) begin
            found_q <= 1'b0;
            state_q <= StSel;
          end
        end
        StMag: begin
          state_q <= StSel;
        end
        StSel: begin
          if (status_i.out_free) begin
            state_q <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

endmodule

>>> src/aabb_pcc_datapath.sv
// Datapath with the platform table, scan pipeline, gap selection and output register.
module aabb_pcc_datapath #(
  parameter int unsigned MAX_PLATFORMS = aabb_pcc_pkg::MaxPlatformsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  aabb_pcc_pkg::dp_cmd_t             cmd_i,
  output aabb_pcc_pkg::dp_status_t          status_o,
  input  logic [aabb_pcc_pkg::SlotW-1:0]    in_slot_i,
  input  aabb_pcc_pkg::entry_t              in_entry_i,
  input  logic [aabb_pcc_pkg::CountW-1:0]   count_i,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic                              out_hit_o,
  output logic signed [aabb_pcc_pkg::CorrW-1:0] out_corr_x_o,
  output logic signed [aabb_pcc_pkg::CorrW-1:0] out_corr_y_o
);

  localparam int unsigned AW = (MAX_PLATFORMS > 1) ? $clog2(MAX_PLATFORMS) : 1;
  localparam int unsigned NW = $clog2(MAX_PLATFORMS + 1);
  localparam int unsigned LW = (NW > aabb_pcc_pkg::CountW) ? NW : aabb_pcc_pkg::CountW;
  localparam int unsigned GW = aabb_pcc_pkg::GapW;
  localparam int unsigned SW = aabb_pcc_pkg::SumW;
  localparam int unsigned CW = aabb_pcc_pkg::CorrW;

  aabb_pcc_pkg::entry_t mem [MAX_PLATFORMS];
  aabb_pcc_pkg::entry_t rdata_q;
  aabb_pcc_pkg::entry_t query_q;

  logic [LW-1:0] idx_q;
  logic [LW-1:0] limit;
  logic [LW-1:0] count_ext;
  logic          rd_en;
  logic          rd_vld_q;
  logic          chk_vld_q;
  logic          chk_hit_q;
  logic          wr_en;

  logic signed [GW-1:0] gap_q [4];
  logic [GW-1:0]        mag_q [4];

  logic signed [SW-1:0] q_x0, q_x1, q_y0, q_y1;
  logic signed [SW-1:0] p_x0, p_x1, p_y0, p_y1;
  logic                 overlap;

  logic                 out_vld_q;
  logic                 out_hit_q;
  logic signed [CW-1:0] out_cx_q;
  logic signed [CW-1:0] out_cy_q;
  logic signed [GW-1:0] sel_gap;
  logic                 sel_is_x;

  // Scan limit is the configured count clipped to the table depth.
  assign count_ext = LW'(count_i);
  assign limit = (count_ext > LW'(MAX_PLATFORMS)) ? LW'(MAX_PLATFORMS) : count_ext;
  assign rd_en = cmd_i.scan_step && (idx_q < limit);
  assign wr_en = cmd_i.write_entry && (int'(in_slot_i) < int'(MAX_PLATFORMS));

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[AW'(in_slot_i)] <= in_entry_i;
    end
    if (rd_en) begin
      rdata_q <= mem[idx_q[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_query) begin
      query_q <= in_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      rd_vld_q <= 1'b0;
      chk_vld_q <= 1'b0;
      chk_hit_q <= 1'b0;
    end else begin
      if (cmd_i.load_query) begin
        idx_q <= '0;
      end else if (rd_en) begin
        idx_q <= idx_q + LW'(1);
      end
      rd_vld_q <= rd_en;
      chk_vld_q <= cmd_i.scan_step && rd_vld_q;
      if (cmd_i.scan_step) begin
        chk_hit_q <= overlap;
      end
    end
  end

  // Edges of the query and of the entry just read, in 17-bit signed form.
  assign q_x0 = SW'(query_q.x);
  assign q_y0 = SW'(query_q.y);
  assign q_x1 = SW'(query_q.x) + $signed({2'b00, query_q.w});
  assign q_y1 = SW'(query_q.y) + $signed({2'b00, query_q.h});
  assign p_x0 = SW'(rdata_q.x);
  assign p_y0 = SW'(rdata_q.y);
  assign p_x1 = SW'(rdata_q.x) + $signed({2'b00, rdata_q.w});
  assign p_y1 = SW'(rdata_q.y) + $signed({2'b00, rdata_q.h});

  assign overlap = (q_x0 < p_x1) && (q_x1 > p_x0) && (q_y0 < p_y1) && (q_y1 > p_y0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_step) begin
      gap_q[0] <= GW'(p_x0) - GW'(q_x1);
      gap_q[1] <= GW'(p_x1) - GW'(q_x0);
      gap_q[2] <= GW'(p_y0) - GW'(q_y1);
      gap_q[3] <= GW'(p_y1) - GW'(q_y0);
    end
    if (cmd_i.mag_load) begin
      for (int k = 0; k < 4; k++) begin
        mag_q[k] <= gap_q[k][GW-1] ? GW'(-gap_q[k]) : GW'(gap_q[k]);
      end
    end
  end

  // Smallest magnitude wins, ties resolved left, right, top, bottom.
  always_comb begin
    if ((mag_q[0] <= mag_q[1]) && (mag_q[0] <= mag_q[2]) && (mag_q[0] <= mag_q[3])) begin
      sel_gap = gap_q[0];
      sel_is_x = 1'b1;
    end else if ((mag_q[1] <= mag_q[2]) && (mag_q[1] <= mag_q[3])) begin
      sel_gap = gap_q[1];
      sel_is_x = 1'b1;
    end else if (mag_q[2] <= mag_q[3]) begin
      sel_gap = gap_q[2];
      sel_is_x = 1'b0;
    end else begin
      sel_gap = gap_q[3];
      sel_is_x = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.result_load) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.result_load) begin
      out_hit_q <= cmd_i.result_hit;
      out_cx_q <= (cmd_i.result_hit && sel_is_x) ? sel_gap[CW-1:0] : '0;
      out_cy_q <= (cmd_i.result_hit && !sel_is_x) ? sel_gap[CW-1:0] : '0;
    end
  end

  assign status_o.found = chk_vld_q && chk_hit_q;
  assign status_o.scan_done = (idx_q >= limit) && !rd_vld_q && !chk_vld_q;
  assign status_o.out_free = !out_vld_q || out_ready_i;

  assign out_valid_o = out_vld_q;
  assign out_hit_o = out_hit_q;
  assign out_corr_x_o = out_cx_q;
  assign out_corr_y_o = out_cy_q;

endmodule

>>> src/aabb_platform_collision_correction_unit.sv
// Top level of the platform collision correction unit with its APB register port.
//
// The request channel in_i carries two kinds of requests. A write request
// (cmd = 0) stores the rectangle in the platform table at the given slot and
// produces no result; slots beyond the table are dropped. A query request
// (cmd = 1) scans the first platform_count table entries in index order and
// returns exactly one result on out_o: the hit flag and the correction vector
// out of the first platform that overlaps the query strictly on both axes.
// A query scans at most the table depth, as platform_count is clipped to it.
// The scan is paced by the single read port of the table, which delivers one
// entry per cycle into a short compare pipeline; on a hit the gap magnitudes
// are formed next, and then the smallest gap is selected.
// The result sits in an output register, so the next request is accepted
// while a result waits; when the receiver stalls and a second query finishes,
// that query holds until the output register frees up.
// platform_count is written over the APB port at byte address 0 and resets
// to zero. Reset clears all control state; the table contents are undefined
// until written and every entry must be written before a query scans it.
module aabb_platform_collision_correction_unit #(
  parameter int unsigned MAX_PLATFORMS = aabb_pcc_pkg::MaxPlatformsDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  aabb_pcc_in_if.sink                         in_i,
  aabb_pcc_out_if.source                      out_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [aabb_pcc_pkg::ApbAddrW-1:0]   paddr,
  input  logic [aabb_pcc_pkg::ApbDataW-1:0]   pwdata,
  output logic [aabb_pcc_pkg::ApbDataW-1:0]   prdata,
  output logic                                pready
);

  aabb_pcc_pkg::dp_cmd_t    dp_cmd;
  aabb_pcc_pkg::dp_status_t dp_status;
  aabb_pcc_pkg::entry_t     in_entry;

  logic [aabb_pcc_pkg::CountW-1:0] count_q;
  logic                            reg_sel;

  // The register index is the word address; only index zero exists.
  assign reg_sel = (paddr[2] == aabb_pcc_pkg::RegPlatformCount);
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      count_q <= pwdata[aabb_pcc_pkg::CountW-1:0];
    end
  end

  assign prdata = reg_sel ? aabb_pcc_pkg::ApbDataW'(count_q) : '0;

  assign in_entry.x = in_i.rect_x;
  assign in_entry.y = in_i.rect_y;
  assign in_entry.w = in_i.rect_w;
  assign in_entry.h = in_i.rect_h;

  aabb_pcc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_cmd_i   (in_i.cmd),
    .in_ready_o (in_i.ready),
    .status_i   (dp_status),
    .cmd_o      (dp_cmd)
  );

  aabb_pcc_datapath #(
    .MAX_PLATFORMS (MAX_PLATFORMS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (dp_cmd),
    .status_o     (dp_status),
    .in_slot_i    (in_i.slot),
    .in_entry_i   (in_entry),
    .count_i      (count_q),
    .out_ready_i  (out_o.ready),
    .out_valid_o  (out_o.valid),
    .out_hit_o    (out_o.hit),
    .out_corr_x_o (out_o.correction_x),
    .out_corr_y_o (out_o.correction_y)
  );

endmodule

>>> dv/aabb_pcc_tb_pkg.sv
// Scoreboard class that predicts and checks the collision corrections of the unit.
package aabb_pcc_tb_pkg;

  timeunit 1ns;
  timeprecision 1ps;

  import aabb_pcc_pkg::*;

  typedef struct {
    logic                    hit;
    logic signed [CorrW-1:0] cx;
    logic signed [CorrW-1:0] cy;
  } push_t;

  class collision_scoreboard;
    entry_t          platforms[MaxPlatformsDef];
    bit [CountW-1:0] active_count;
    push_t           pending[$];
    int unsigned     errors;
    int unsigned     writes;
    int unsigned     queries;
    int unsigned     hits;

    function void set_count(bit [CountW-1:0] value);
      active_count = value;
    endfunction

    // Called for every accepted request. A write updates the table copy, and a
    // query pushes the correction that the unit must return for it.
    function void note_request(logic cmd, logic [SlotW-1:0] slot, entry_t rect);
      push_t want;
      int    n, best, mag, sel;
      int    qx0, qx1, qy0, qy1, px0, px1, py0, py1;
      int    gap[4];
      if (cmd == CmdWrite) begin
        if (slot < MaxPlatformsDef) platforms[slot] = rect;
        writes++;
        return;
      end
      want.hit = 1'b0;
      want.cx  = '0;
      want.cy  = '0;
      n   = (active_count > MaxPlatformsDef) ? MaxPlatformsDef : active_count;
      qx0 = $signed(rect.x);
      qy0 = $signed(rect.y);
      qx1 = qx0 + int'(rect.w);
      qy1 = qy0 + int'(rect.h);
      for (int i = 0; i < n; i++) begin
        px0 = $signed(platforms[i].x);
        py0 = $signed(platforms[i].y);
        px1 = px0 + int'(platforms[i].w);
        py1 = py0 + int'(platforms[i].h);
        if (qx0 < px1 && qx1 > px0 && qy0 < py1 && qy1 > py0) begin
          gap[0] = px0 - qx1;
          gap[1] = px1 - qx0;
          gap[2] = py0 - qy1;
          gap[3] = py1 - qy0;
          // Strictly smaller wins, so equal magnitudes keep the earlier gap.
          sel  = 0;
          best = (gap[0] < 0) ? -gap[0] : gap[0];
          for (int k = 1; k < 4; k++) begin
            mag = (gap[k] < 0) ? -gap[k] : gap[k];
            if (mag < best) begin
              best = mag;
              sel  = k;
            end
          end
          want.hit = 1'b1;
          if (sel < 2) want.cx = CorrW'(gap[sel]);
          else want.cy = CorrW'(gap[sel]);
          break;
        end
      end
      queries++;
      if (want.hit) hits++;
      pending.push_back(want);
    endfunction

    function void check_result(logic hit, logic signed [CorrW-1:0] cx,
                               logic signed [CorrW-1:0] cy);
      push_t want;
      if (pending.size() == 0) begin
        $display("%0t: result with no query waiting (hit %0b x %0d y %0d)",
                 $time, hit, cx, cy);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (hit !== want.hit) begin
        $display("%0t: hit expected %0b got %0b", $time, want.hit, hit);
        errors++;
      end
      if (cx !== want.cx) begin
        $display("%0t: correction_x expected %0d got %0d", $time, want.cx, cx);
        errors++;
      end
      if (cy !== want.cy) begin
        $display("%0t: correction_y expected %0d got %0d", $time, want.cy, cy);
        errors++;
      end
    endfunction
  endclass

endpackage

>>> dv/tb_aabb_platform_collision_correction_unit.sv
// Testbench top that drives table writes and queries into the unit and checks every correction.
//
// The table is filled completely right after reset, so no query ever scans an
// entry that was never written. A short directed part then covers each gap
// direction, the tie order, first-hit priority, empty rectangles and the
// coordinate extremes. The random part runs in phases, each with its own
// platform_count (zero, one, the table depth and values above it among them),
// and most queries are aimed at an active platform so that hits are common.
// The scoreboard predicts each query's result when the request is accepted
// and compares the results in order as they leave the unit.
module tb_aabb_platform_collision_correction_unit;

  timeunit 1ns;
  timeprecision 1ps;

  import aabb_pcc_pkg::*;
  import aabb_pcc_tb_pkg::*;

  localparam int unsigned DrainCycles = 2 * MaxPlatformsDef + 16;
  localparam int unsigned CycleLimit  = 1_000_000;
  localparam int unsigned NumPhases   = 7;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  aabb_pcc_in_if  req_if ();
  aabb_pcc_out_if push_if ();

  collision_scoreboard sb = new();

  // Idling on both channels is switched off for some phases and for the end.
  bit          idle_on;
  int unsigned cycle_count;
  int unsigned ready_stall;

  aabb_platform_collision_correction_unit u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (req_if),
    .out_o   (push_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #6 clk_i = ~clk_i;

  // A watchdog ends a run that hangs; the limit is several times the slowest
  // correct run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("%0t: timeout after %0d cycles, %0d queries still waiting", $time,
               cycle_count, sb.pending.size());
      $display("tb_aabb_platform_collision_correction_unit failed");
      $finish;
    end
  end

  // Every accepted result is checked against the oldest predicted one. Values
  // are read at the clock edge, before any register of the edge updates.
  always @(posedge clk_i) begin
    if (rst_ni && push_if.valid && push_if.ready) begin
      sb.check_result(push_if.hit, push_if.correction_x, push_if.correction_y);
    end
  end

  // The receiver stalls in random bursts while idling is on.
  initial begin
    push_if.ready <= 1'b0;
    ready_stall = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (ready_stall > 0) begin
        ready_stall--;
        push_if.ready <= (ready_stall == 0);
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        ready_stall = $urandom_range(1, 15);
        push_if.ready <= 1'b0;
      end else begin
        push_if.ready <= 1'b1;
      end
    end
  end

  function automatic entry_t make_rect(int x, int y, int w, int h);
    entry_t r;
    r.x = CoordW'(x);
    r.y = CoordW'(y);
    r.w = SizeW'(w);
    r.h = SizeW'(h);
    return r;
  endfunction

  function automatic logic signed [CoordW-1:0] clamp_coord(int v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return CoordW'(v);
  endfunction

  // Most platforms sit on a coarse grid in a small arena, which makes overlaps
  // and equal gaps frequent; the rest span the full range or its edges.
  function automatic entry_t random_platform();
    entry_t p;
    case ($urandom_range(0, 9))
      0, 1: begin
        p.x = CoordW'($urandom);
        p.y = CoordW'($urandom);
        p.w = SizeW'($urandom);
        p.h = SizeW'($urandom);
      end
      2: begin
        p.x = $urandom_range(0, 1) ? 16'sh8000 : 16'sh7fff;
        p.y = $urandom_range(0, 1) ? 16'sh8000 : 16'sh7fff;
        p.w = $urandom_range(0, 1) ? 15'h7fff : 15'h0;
        p.h = $urandom_range(0, 1) ? 15'h7fff : 15'h0;
      end
      default: begin
        p = make_rect(int'($urandom_range(0, 256)) * 16 - 2048,
                      int'($urandom_range(0, 256)) * 16 - 2048,
                      $urandom_range(1, 64) * 16, $urandom_range(1, 64) * 16);
        if ($urandom_range(0, 3) == 0) p.w = p.w + SizeW'($urandom_range(0, 15));
        if ($urandom_range(0, 3) == 0) p.y = p.y + CoordW'($urandom_range(0, 15));
      end
    endcase
    return p;
  endfunction

  // Presents one request and holds it until the unit takes it. The valid
  // stays high between back-to-back requests.
  task automatic send_request(input logic cmd, input logic [SlotW-1:0] slot,
                              input entry_t rect);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    req_if.valid  <= 1'b1;
    req_if.cmd    <= cmd;
    req_if.slot   <= slot;
    req_if.rect_x <= rect.x;
    req_if.rect_y <= rect.y;
    req_if.rect_w <= rect.w;
    req_if.rect_h <= rect.h;
    do @(posedge clk_i); while (!req_if.ready);
    sb.note_request(cmd, slot, rect);
  endtask

  // Drops the valid after the last request of a phase, waits for every
  // outstanding result and then lets a trailing write or scan finish.
  task automatic wait_idle();
    req_if.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // APB write of platform_count followed by a read back of the register.
  task automatic write_platform_count(input bit [CountW-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {RegPlatformCount, 2'b00};
    pwdata  <= ApbDataW'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_count(value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    psel    <= 1'b1;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== ApbDataW'(value)) begin
      $display("%0t: platform_count read expected %0d got %0d", $time, value, prdata);
      sb.errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Random requests: one in five rewrites a table slot, the rest are queries.
  // Most queries are placed around one of the active platforms, half of them
  // snapped to the grid so that ties between gaps show up.
  task automatic run_random(input int unsigned count);
    entry_t      p;
    entry_t      r;
    int unsigned span;
    int          qw, qh, tx, ty;
    bit          grid;
    repeat (count) begin
      if ($urandom_range(0, 4) == 0) begin
        send_request(CmdWrite, SlotW'($urandom), random_platform());
      end else begin
        span = (sb.active_count > MaxPlatformsDef) ? MaxPlatformsDef : sb.active_count;
        if ($urandom_range(0, 9) < 2) begin
          r = random_platform();
        end else begin
          p    = sb.platforms[$urandom_range(0, (span == 0) ? MaxPlatformsDef - 1 : span - 1)];
          grid = $urandom_range(0, 1);
          qw   = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 32767) : $urandom_range(0, 600);
          qh   = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 32767) : $urandom_range(0, 600);
          if (grid) begin
            qw = qw / 16 * 16;
            qh = qh / 16 * 16;
          end
          tx = $signed(p.x) - qw + int'($urandom_range(0, int'(p.w) + qw));
          ty = $signed(p.y) - qh + int'($urandom_range(0, int'(p.h) + qh));
          if (grid) begin
            tx = (tx >>> 4) <<< 4;
            ty = (ty >>> 4) <<< 4;
          end
          r.x = clamp_coord(tx);
          r.y = clamp_coord(ty);
          r.w = SizeW'(qw);
          r.h = SizeW'(qh);
        end
        send_request(CmdQuery, SlotW'($urandom), r);
      end
    end
  endtask

  initial begin
    bit [CountW-1:0] phase_count[NumPhases];
    int unsigned     phase_items[NumPhases];
    bit              phase_idle[NumPhases];
    rst_ni         = 1'b0;
    idle_on        = 1'b1;
    cycle_count    = 0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    req_if.valid  <= 1'b0;
    req_if.cmd    <= CmdWrite;
    req_if.slot   <= '0;
    req_if.rect_x <= '0;
    req_if.rect_y <= '0;
    req_if.rect_w <= '0;
    req_if.rect_h <= '0;
    phase_count = '{7'd64, 7'd1, 7'd127, 7'd0, 7'd100,
                    CountW'($urandom_range(2, 63)), 7'd64};
    phase_items = '{300, 200, 300, 100, 300, 250, 300};
    phase_idle  = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Every slot gets a platform before any query is allowed to scan it. While
    // platform_count is still at its reset value of zero, a query has no
    // active zone and must miss.
    for (int s = 0; s < MaxPlatformsDef; s++) begin
      send_request(CmdWrite, SlotW'(s), random_platform());
    end
    send_request(CmdQuery, '0, make_rect(0, 0, 32767, 32767));
    wait_idle();

    // Directed part over four entries: a 160 by 160 square at the origin, the
    // full negative quadrant, the far positive corner and an empty platform.
    write_platform_count(7'd4);
    send_request(CmdWrite, 6'd0, make_rect(0, 0, 160, 160));
    send_request(CmdWrite, 6'd1, make_rect(-32768, -32768, 32767, 32767));
    send_request(CmdWrite, 6'd2, make_rect(32767, 32767, 32767, 32767));
    send_request(CmdWrite, 6'd3, make_rect(0, 0, 0, 160));
    send_request(CmdQuery, 6'd63, make_rect(4000, 4000, 16, 16));     // clean miss
    send_request(CmdQuery, 6'd0, make_rect(32, 32, 0, 32));           // empty query
    send_request(CmdQuery, 6'd0, make_rect(-16, 40, 32, 80));         // push left
    send_request(CmdQuery, 6'd0, make_rect(150, 40, 32, 80));         // push right
    send_request(CmdQuery, 6'd0, make_rect(40, -8, 80, 24));          // push up
    send_request(CmdQuery, 6'd0, make_rect(40, 150, 80, 32));         // push down
    send_request(CmdQuery, 6'd0, make_rect(64, -200, 32, 560));       // left ties right
    send_request(CmdQuery, 6'd0, make_rect(64, 64, 32, 32));          // all four tie
    send_request(CmdQuery, 6'd0, make_rect(120, -40, 200, 80));       // right ties top
    send_request(CmdQuery, 6'd0, make_rect(-200, 64, 560, 32));       // top ties bottom
    send_request(CmdQuery, 6'd0, make_rect(-16, -16, 32, 32));        // first entry wins
    send_request(CmdQuery, 6'd0, make_rect(-32768, -32768, 32767, 32767));
    send_request(CmdQuery, 6'd0, make_rect(32767, 32767, 32767, 32767));
    send_request(CmdQuery, 6'd0, make_rect(32767, 0, 0, 32767));
    send_request(CmdQuery, 6'd0, make_rect(-32768, 32767, 32767, 1));
    wait_idle();

    // Random phases. A count above the table depth must scan the whole table,
    // and a count of zero must miss every query.
    for (int ph = 0; ph < NumPhases; ph++) begin
      idle_on = phase_idle[ph];
      write_platform_count(phase_count[ph]);
      run_random(phase_items[ph]);
      wait_idle();
    end

    $display("Checked %0d queries (%0d hits) against %0d table writes.",
             sb.queries, sb.hits, sb.writes);
    $display("platform_count took %0d settings, including 0, 1, 64 and 127.",
             NumPhases + 1);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb_aabb_platform_collision_correction_unit passed");
    end else begin
      $display("%0d mismatches, %0d queries without a result", sb.errors,
               sb.pending.size());
      $display("tb_aabb_platform_collision_correction_unit failed");
    end
    $finish;
  end

endmodule

>>> aabb_platform_collision_correction_unit.f
src/aabb_pcc_pkg.sv
src/aabb_pcc_in_if.sv
src/aabb_pcc_out_if.sv
src/aabb_pcc_ctrl.sv
src/aabb_pcc_datapath.sv
src/aabb_platform_collision_correction_unit.sv
dv/aabb_pcc_tb_pkg.sv
dv/tb_aabb_platform_collision_correction_unit.sv
